### hw/rtl/mexp_pkg.sv
// Shared types, constants and the microprogram ROM of the modular exponentiation unit.
// Used by mexp_mulmod, mexp_seq and modular_exponentiation_unit; depends on nothing.
`default_nettype none

package mexp_pkg;

	// Field widths.
	localparam int EXP_WIDTH = 63;
	localparam int BASE_W    = 63;
	localparam int MOD_W     = 32;

	localparam logic [MOD_W-1:0] MOD_RESET = 32'd998244353;

	// Step counter of the shared modular multiply/reduce unit.
	localparam int CNT_W = $clog2(BASE_W + 1);
	localparam logic [CNT_W-1:0] RED_STEPS = CNT_W'(BASE_W);
	localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MOD_W);

	// Microprogram counter.
	localparam int PC_W = 4;

	localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
	localparam logic [PC_W-1:0] PC_RED_GO   = 4'd1;
	localparam logic [PC_W-1:0] PC_RED_WAIT = 4'd2;
	localparam logic [PC_W-1:0] PC_CHECK    = 4'd3;
	localparam logic [PC_W-1:0] PC_MUL_GO   = 4'd4;
	localparam logic [PC_W-1:0] PC_MUL_WAIT = 4'd5;
	localparam logic [PC_W-1:0] PC_SQR_GO   = 4'd6;
	localparam logic [PC_W-1:0] PC_SQR_WAIT = 4'd7;
	localparam logic [PC_W-1:0] PC_LOOP     = 4'd8;
	localparam logic [PC_W-1:0] PC_DONE     = 4'd9;
	localparam logic [PC_W-1:0] PC_RETURN   = 4'd10;

	typedef enum logic [1:0] {
		UOP_NONE,
		UOP_RED,
		UOP_MUL,
		UOP_SQR
	} uop_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_PW,
		WR_RES
	} wr_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_START,
		C_UNIT_BUSY,
		C_EXP_ZERO,
		C_EXP_BIT_CLR
	} cond_t;

	typedef enum logic {
		MM_RED,
		MM_MUL
	} mm_mode_t;

	// One microinstruction. Actions fire only when the jump is not taken.
	typedef struct packed {
		uop_t            uop;
		wr_t             wr;
		logic            load;
		logic            shift_exp;
		logic            done;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	// Actions handed from the sequencer to the datapath.
	typedef struct packed {
		uop_t uop;
		wr_t  wr;
		logic load;
		logic shift_exp;
		logic done;
	} ctl_t;

	// Conditions reported by the datapath to the sequencer.
	typedef struct packed {
		logic start;
		logic unit_busy;
		logic exp_zero;
		logic exp_bit;
	} stat_t;

	function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{uop: UOP_NONE, wr: WR_NONE, load: 1'b0, shift_exp: 1'b0, done: 1'b0,
			cond: C_NEVER, target: PC_IDLE};
		case (pc)
			PC_IDLE: begin
				w.cond   = C_NO_START;
				w.target = PC_IDLE;
				w.load   = 1'b1;
			end
			PC_RED_GO: begin
				w.uop = UOP_RED;
			end
			PC_RED_WAIT: begin
				w.cond   = C_UNIT_BUSY;
				w.target = PC_RED_WAIT;
				w.wr     = WR_PW;
			end
			PC_CHECK: begin
				w.cond   = C_EXP_ZERO;
				w.target = PC_DONE;
			end
			PC_MUL_GO: begin
				w.cond   = C_EXP_BIT_CLR;
				w.target = PC_SQR_GO;
				w.uop    = UOP_MUL;
			end
			PC_MUL_WAIT: begin
				w.cond   = C_UNIT_BUSY;
				w.target = PC_MUL_WAIT;
				w.wr     = WR_RES;
			end
			PC_SQR_GO: begin
				w.uop       = UOP_SQR;
				w.shift_exp = 1'b1;
			end
			PC_SQR_WAIT: begin
				w.cond   = C_UNIT_BUSY;
				w.target = PC_SQR_WAIT;
				w.wr     = WR_PW;
			end
			PC_LOOP: begin
				w.cond   = C_ALWAYS;
				w.target = PC_CHECK;
			end
			PC_DONE: begin
				w.done = 1'b1;
			end
			PC_RETURN: begin
				w.cond   = C_ALWAYS;
				w.target = PC_IDLE;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/mexp_mulmod.sv
// Shared bit-serial modular multiply and reduce unit, one operand bit per cycle.
// Depends on mexp_pkg.
`default_nettype none

module mexp_mulmod import mexp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire mm_mode_t         mode,
	input  wire logic [MOD_W-1:0]  a,
	input  wire logic [MOD_W-1:0]  b,
	input  wire logic [BASE_W-1:0] base,
	input  wire logic [MOD_W:0]    m,
	output logic                  busy,
	output logic [MOD_W-1:0]       r
);

	logic [CNT_W-1:0]  cnt_q;
	mm_mode_t          mode_q;
	logic [MOD_W-1:0]  a_q;
	logic [BASE_W-1:0] seq_q;
	logic [MOD_W-1:0]  r_q;

	logic              bit_in;
	logic [MOD_W-1:0]  addend;
	logic [MOD_W+1:0]  sum;
	logic [MOD_W+1:0]  m1;
	logic [MOD_W+1:0]  m2;
	logic [MOD_W+1:0]  red;

	assign busy   = (cnt_q != '0);
	assign r      = r_q;
	assign bit_in = seq_q[BASE_W-1];

	// The running remainder stays below m, so 2r plus an addend of at most m
	// is below 3m and one of three candidates is the reduced value.
	always_comb begin
		if (mode_q == MM_RED) begin
			addend = {{(MOD_W-1){1'b0}}, bit_in};
		end else begin
			addend = bit_in ? a_q : '0;
		end
		sum = {1'b0, r_q, 1'b0} + {2'b00, addend};
		m1  = {1'b0, m};
		m2  = {m, 1'b0};
		if (sum >= m2) begin
			red = sum - m2;
		end else if (sum >= m1) begin
			red = sum - m1;
		end else begin
			red = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= (mode == MM_RED) ? RED_STEPS : MUL_STEPS;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= mode;
			a_q    <= a;
			r_q    <= '0;
			if (mode == MM_RED) begin
				seq_q <= base;
			end else begin
				seq_q <= {b, {(BASE_W-MOD_W){1'b0}}};
			end
		end else if (busy) begin
			seq_q <= {seq_q[BASE_W-2:0], 1'b0};
			r_q   <= red[MOD_W-1:0];
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("multiply unit started while busy");

endmodule

`default_nettype wire

### hw/rtl/mexp_seq.sv
// Microprogram sequencer: step counter, ROM lookup and conditional jumps.
// Depends on mexp_pkg for the ROM contents and control types.
`default_nettype none

module mexp_seq import mexp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire stat_t st,
	output ctl_t       ctl,
	output logic       busy
);

	logic [PC_W-1:0] pc_q;
	uword_t          uw;
	logic            taken;

	assign uw   = ucode_rom(pc_q);
	assign busy = (pc_q != PC_IDLE);

	always_comb begin
		case (uw.cond)
			C_NEVER:       taken = 1'b0;
			C_ALWAYS:      taken = 1'b1;
			C_NO_START:    taken = !st.start;
			C_UNIT_BUSY:   taken = st.unit_busy;
			C_EXP_ZERO:    taken = st.exp_zero;
			C_EXP_BIT_CLR: taken = !st.exp_bit;
			default:       taken = 1'b0;
		endcase
		ctl.uop       = taken ? UOP_NONE : uw.uop;
		ctl.wr        = taken ? WR_NONE : uw.wr;
		ctl.load      = uw.load && !taken;
		ctl.shift_exp = uw.shift_exp && !taken;
		ctl.done      = uw.done && !taken;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= taken ? uw.target : pc_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/modular_exponentiation_unit.sv
// Top level of the modular exponentiation unit: operand registers and glue.
// Depends on mexp_pkg, mexp_seq and mexp_mulmod.
//
// Channel    Direction  Signals                                 Beat taken when
// ---------  ---------  --------------------------------------  ----------------------------
// command    in         start, busy, base, exponent             start && !busy
// result     out        done, result                            done (one cycle, no stall)
// modulus    in         modulus_valid, modulus_ready, modulus   modulus_valid && modulus_ready
//
// Each item reduces the base, then for every exponent bit up to the highest set bit
// squares the power, with a multiply into the result first where the bit is set.
// The run time is set by the single bit-serial multiply/reduce unit, which does the
// base reduction and every modular product, one product at a time.
// Reset clears the sequencer to idle, drops done and loads the modulus with 998244353.
// The result beat cannot be stalled; busy stays high through the cycle that shows it.
`default_nettype none

module modular_exponentiation_unit import mexp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [BASE_W-1:0]    base,
	input  wire logic [EXP_WIDTH-1:0] exponent,
	output logic                      done,
	output logic [MOD_W-1:0]          result,
	input  wire logic                 modulus_valid,
	output logic                      modulus_ready,
	input  wire logic [MOD_W-1:0]     modulus
);

	// Datapath registers. The power and the running result are always
	// held below the modulus, except the initial result of 1.
	logic [MOD_W-1:0]     mod_q;
	logic [BASE_W-1:0]    base_q;
	logic [EXP_WIDTH-1:0] exp_q;
	logic [MOD_W-1:0]     pw_q;
	logic [MOD_W-1:0]     res_q;
	logic [MOD_W-1:0]     result_q;
	logic                 done_q;

	ctl_t                 ctl;
	stat_t                st;
	logic                 seq_busy;

	logic                 mm_start;
	mm_mode_t             mm_mode;
	logic [MOD_W-1:0]     mm_a;
	logic [MOD_W:0]       mm_m;
	logic                 mm_busy;
	logic [MOD_W-1:0]     mm_r;

	assign busy          = seq_busy;
	assign modulus_ready = !seq_busy;
	assign done          = done_q;
	assign result        = result_q;

	// A modulus of zero stands for 2^32, so the unit works on a 33-bit modulus.
	assign mm_m = {(mod_q == '0), mod_q};

	// The sequencer only sees start in its idle step, which is where a beat lands.
	assign st.start     = start;
	assign st.unit_busy = mm_busy;
	assign st.exp_zero  = (exp_q == '0);
	assign st.exp_bit   = exp_q[0];

	// Squaring and the base reduction both feed the power; a multiply step
	// takes the running result as the addend and the power as multiplier.
	assign mm_start = (ctl.uop != UOP_NONE);
	assign mm_mode  = (ctl.uop == UOP_RED) ? MM_RED : MM_MUL;
	assign mm_a     = (ctl.uop == UOP_MUL) ? res_q : pw_q;

	mexp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctl    (ctl),
		.busy   (seq_busy)
	);

	mexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.mode   (mm_mode),
		.a      (mm_a),
		.b      (pw_q),
		.base   (base_q),
		.m      (mm_m),
		.busy   (mm_busy),
		.r      (mm_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= MOD_RESET;
			done_q <= 1'b0;
		end else begin
			if (modulus_valid && modulus_ready) begin
				mod_q <= modulus;
			end
			done_q <= ctl.done;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			base_q <= base;
			exp_q  <= exponent;
			res_q  <= {{(MOD_W-1){1'b0}}, 1'b1};
		end else begin
			if (ctl.shift_exp) begin
				exp_q <= {1'b0, exp_q[EXP_WIDTH-1:1]};
			end
			case (ctl.wr)
				WR_PW:   pw_q  <= mm_r;
				WR_RES:  res_q <= mm_r;
				default: ;
			endcase
		end
		if (ctl.done) begin
			result_q <= res_q;
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat shown while idle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_mod_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> $stable(mod_q))
		else $error("modulus changed during an operation");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for modular_exponentiation_unit: directed and random
// base/exponent commands under several modulus settings. Depends on mexp_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
	import mexp_pkg::*;

	// The slowest correct run is roughly 150 commands at their longest, plus
	// sender gaps; the limit leaves several times that.
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int MAX_REPORTS = 10;

	// One accepted command together with the result it must produce.
	typedef struct {
		logic [BASE_W-1:0]    base;
		logic [EXP_WIDTH-1:0] exponent;
		logic [MOD_W-1:0]     modulus;
		logic [MOD_W-1:0]     result;
	} mexp_job_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [BASE_W-1:0]    base = '0;
	logic [EXP_WIDTH-1:0] exponent = '0;
	logic                 modulus_valid = 1'b0;
	logic [MOD_W-1:0]     modulus = '0;
	wire logic            busy;
	wire logic            done;
	wire logic [MOD_W-1:0] result;
	wire logic            modulus_ready;

	// Our own copy of the modulus register, updated at each write beat.
	logic [MOD_W-1:0] modulus_shadow = MOD_RESET;

	// Results still owed by the block, oldest first.
	mexp_job_t pending_powers[$];

	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned commands_sent = 0;
	int unsigned results_seen = 0;
	int unsigned modulus_writes = 0;
	int unsigned sender_idle_pct = 0;

	modular_exponentiation_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.base         (base),
		.exponent     (exponent),
		.done         (done),
		.result       (result),
		.modulus_valid(modulus_valid),
		.modulus_ready(modulus_ready),
		.modulus      (modulus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Reduction by the modulus. A zero modulus stands for 2^32, so only the
	// low 32 bits survive; the stimulus never configures it, but the rule is kept.
	function automatic logic [63:0] mod_reduce(input logic [63:0] v, input logic [MOD_W-1:0] m);
		if (m == '0)
			return {32'd0, v[31:0]};
		return v % {32'd0, m};
	endfunction

	// Right-to-left square-and-multiply over the low EXP_WIDTH exponent bits.
	// The accumulator starts at 1 and is never reduced unless a bit is set,
	// which is why a zero exponent yields 1 even with a modulus of one.
	function automatic logic [MOD_W-1:0] mod_power(input logic [BASE_W-1:0] b,
			input logic [EXP_WIDTH-1:0] e, input logic [MOD_W-1:0] m);
		logic [63:0] pw;
		logic [63:0] acc;
		pw  = mod_reduce(64'(b), m);
		acc = 64'd1;
		for (int i = 0; i < EXP_WIDTH; i++) begin
			if (e[i])
				acc = mod_reduce(acc * pw, m);
			pw = mod_reduce(pw * pw, m);
		end
		return acc[MOD_W-1:0];
	endfunction

	function automatic logic [62:0] rand63();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[62:0];
	endfunction

	task automatic report_mismatch(input string what, input mexp_job_t job, input logic [MOD_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] %s: base=%h exponent=%h modulus=%0d expected=%h actual=%h",
				$realtime, what, job.base, job.exponent, job.modulus, job.result, got);
	endtask

	// Send one command beat. With sender idling enabled, start is dropped after
	// the previous beat, the testbench waits for busy to fall and then idles a
	// random number of cycles, so the new command lands at varying points.
	// Without idling, start stays high and the next command is taken the moment
	// the block goes idle.
	task automatic send_command(input logic [BASE_W-1:0] b, input logic [EXP_WIDTH-1:0] e);
		mexp_job_t job;
		if (sender_idle_pct != 0) begin
			start <= 1'b0;
			@(posedge clk);
			while (busy)
				@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct)
				@(posedge clk);
		end
		start    <= 1'b1;
		base     <= b;
		exponent <= e;
		do
			@(posedge clk);
		while (busy);
		job.base     = b;
		job.exponent = e;
		job.modulus  = modulus_shadow;
		job.result   = mod_power(b, e, modulus_shadow);
		pending_powers.insert(pending_powers.size(), job);
		commands_sent++;
	endtask

	// Stop sending and wait until every owed result has arrived and the block
	// has left its busy state, so the modulus may be rewritten safely.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_powers.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_modulus(input logic [MOD_W-1:0] value);
		modulus_valid <= 1'b1;
		modulus       <= value;
		do
			@(posedge clk);
		while (!modulus_ready);
		modulus_valid  <= 1'b0;
		modulus_shadow  = value;
		modulus_writes++;
	endtask

	// Result checker. done is sampled at the edge that ends its cycle; the
	// block cannot be stalled, so every strobe is a beat.
	always @(posedge clk) begin : result_check
		mexp_job_t job;
		if (arst_n && done) begin
			results_seen++;
			if (pending_powers.size() == 0) begin
				job = '{default: '0};
				report_mismatch("result with nothing outstanding", job, result);
			end else begin
				job = pending_powers.pop_front();
				if (result !== job.result)
					report_mismatch("result mismatch", job, result);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_powers.size());
			$display("tb NOT OK");
			$finish;
		end
	end

	// The reset value of the modulus, with the edges of both fields, a zero
	// base, a base that is a multiple of the modulus and a Fermat check.
	task automatic test_reset_modulus();
		send_command('0, '0);
		send_command('0, 63'd1);
		send_command('1, '0);
		send_command('1, '1);
		send_command(63'd2, 63'(MOD_RESET - 1));
		send_command(63'(MOD_RESET), 63'd5);
		send_command(63'd1, '1);
		send_command(63'd3, 63'd1);
		drain_results();
	endtask

	// A modulus of one: zero exponent still gives 1, anything else gives 0.
	task automatic test_modulus_one();
		write_modulus(32'd1);
		send_command(63'd5, '0);
		send_command(63'd5, 63'd1);
		send_command('1, '1);
		send_command('0, '0);
		drain_results();
	endtask

	// The largest modulus, where products come closest to 64 bits.
	task automatic test_modulus_max();
		write_modulus(32'hFFFF_FFFF);
		send_command('1, '1);
		send_command(63'h0_FFFF_FFFE, 63'd2);
		send_command(63'h0_FFFF_FFFF, 63'd3);
		send_command(63'h1_0000_0000, 63'd7);
		send_command(63'h0_FFFF_FFFE, '1);
		drain_results();
	endtask

	// Random commands in two halves with a modulus change between them; the
	// change forces a full pause until every result has come back.
	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned count);
		logic [MOD_W-1:0]     m;
		logic [BASE_W-1:0]    b;
		logic [EXP_WIDTH-1:0] e;
		sender_idle_pct = idle_pct;
		for (int half = 0; half < 2; half++) begin
			drain_results();
			case ($urandom_range(5))
				0: m = 32'd1;
				1: m = 32'd2;
				2: m = 32'hFFFF_FFFF;
				3: m = MOD_RESET;
				4: m = $urandom | 32'h8000_0000;
				default: m = $urandom_range(3, 1000);
			endcase
			write_modulus(m);
			for (int n = 0; n < count / 2; n++) begin
				case ($urandom_range(5))
					0: b = rand63();
					1: b = 63'($urandom_range(0, 20));
					2: b = 63'(m) * 63'($urandom_range(0, 4));
					3: b = '1;
					default: b = 63'($urandom);
				endcase
				// Short exponents keep the run brief; full-width ones reach
				// every bit and the longest square-and-multiply chains.
				case ($urandom_range(9))
					0: e = '0;
					1: e = 63'd1 << $urandom_range(EXP_WIDTH - 1);
					2: e = '1;
					3, 4, 5: e = rand63();
					default: e = 63'($urandom_range(1, 4095));
				endcase
				send_command(b, e);
			end
		end
		drain_results();
	endtask

	initial begin
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_modulus();
		test_modulus_one();
		test_modulus_max();
		test_random_traffic(9, 42);
		test_random_traffic(82, 42);
		test_random_traffic(0, 42);

		drain_results();
		// Any stray strobe after the last expected result would show up here.
		repeat (200)
			@(posedge clk);

		$display("covered %0d commands and %0d results over %0d modulus writes in %0d cycles",
			commands_sent, results_seen, modulus_writes, cycle_count);
		$display("moduli included 1, 2, 2^32-1 and the reset value; %0d mismatches",
			mismatch_count + pending_powers.size());
		if (mismatch_count == 0 && pending_powers.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_mulmod.sv
hw/rtl/mexp_seq.sv
hw/rtl/modular_exponentiation_unit.sv
tb/tb.sv
